// ----- hdl/sprda_pkg.sv -----
// ----------------------------------------------------------------------------
// Setpoint ramp and deviation alarm package
// Shared widths, operation codes, register indexes and saturation helpers.
// ----------------------------------------------------------------------------
package sprda_pkg;

   // Field widths.
   localparam int VALUE_W   = 32;
   localparam int TICK_W    = 16;
   localparam int THRESH_W  = 31;
   localparam int ADDR_W    = 5;
   localparam int CSR_W     = 32;
   localparam int REQ_W     = 88;
   localparam int RSP_W     = 40;

   // Divider runs one quotient bit per step over a magnitude one bit wider
   // than a value.
   localparam int DIV_STEPS = VALUE_W + 1;

   // Operation codes carried in the request tuser.
   localparam logic [1:0] OP_SET_TARGET  = 2'd0;
   localparam logic [1:0] OP_TICK        = 2'd1;
   localparam logic [1:0] OP_RESET_ALARM = 2'd2;

   // Alarm state codes.
   localparam logic [1:0] ST_NORMAL  = 2'd0;
   localparam logic [1:0] ST_CAUTION = 2'd1;
   localparam logic [1:0] ST_ALARM   = 2'd2;

   // Register indexes (word address bits).
   localparam logic [2:0] REG_CAUTION_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_ALARM_THRESHOLD   = 3'd1;
   localparam logic [2:0] REG_DELAY_TICKS       = 3'd2;
   localparam logic [2:0] REG_CAUTION_ENABLE    = 3'd3;
   localparam logic [2:0] REG_ALARM_ENABLE      = 3'd4;
   localparam logic [2:0] REG_SHUTDOWN_ON_ALARM = 3'd5;
   localparam logic [2:0] REG_POINT_ALARMS_OFF  = 3'd6;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {1'b0, {(VALUE_W-1){1'b1}}};
   localparam logic [VALUE_W-1:0] VALUE_MIN = {1'b1, {(VALUE_W-1){1'b0}}};
   localparam logic [TICK_W-1:0]  TICK_MAX  = {TICK_W{1'b1}};

   // Saturate a value that is one bit wider than the value range.
   function automatic logic [VALUE_W-1:0] sat_one(input logic [VALUE_W:0] v);
      logic [VALUE_W-1:0] r;
      if (v[VALUE_W] != v[VALUE_W-1]) begin
         r = v[VALUE_W] ? VALUE_MIN : VALUE_MAX;
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   // Saturate a value that is two bits wider than the value range.
   function automatic logic [VALUE_W-1:0] sat_two(input logic [VALUE_W+1:0] v);
      logic [VALUE_W-1:0] r;
      if (!v[VALUE_W+1] && (v[VALUE_W:VALUE_W-1] != 2'b00)) begin
         r = VALUE_MAX;
      end else if (v[VALUE_W+1] && (v[VALUE_W:VALUE_W-1] != 2'b11)) begin
         r = VALUE_MIN;
      end else begin
         r = v[VALUE_W-1:0];
      end
      return r;
   endfunction

   // Tick counter increment that holds at its maximum.
   function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] v);
      return (v == TICK_MAX) ? v : v + 1'b1;
   endfunction

endpackage

// ----- hdl/setpoint_ramp_deviation_alarm.sv -----
// Sequence: a target word with a nonzero ramp length goes through dispatch, the
// serial divider (one quotient bit per cycle), the step load and the output load;
// a tick word through dispatch, tick evaluation and output load; others through
// dispatch and output load. One word at a time: the next is accepted the cycle
// after the previous result is loaded. Reset (synchronous, active high) clears
// control, ramp, alarm and configuration state; payload registers are not reset.
// ----------------------------------------------------------------------------
// Setpoint ramp with deviation alarm
// Ramps a Q16.16 setpoint toward a target with a serial divider for
// the step, and grades the deviation from the measured value on each tick.
// ----------------------------------------------------------------------------
module setpoint_ramp_deviation_alarm import sprda_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   // Request: tdata = target_value[31:0], ramp_ticks[47:32],
   // measured_value[79:48], global_alarms_off[80], zero fill above.
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [REQ_W-1:0]   req_tdata,
   // Request: tuser = operation[1:0].
   input  logic [1:0]         req_tuser,
   // Response: tdata = current_setpoint[31:0], ramp_active[32],
   // alarm_state[34:33], shutdown_trip[35], zero fill above.
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [RSP_W-1:0]   rsp_tdata,
   // Register port.
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [CSR_W-1:0]   csr_pwdata,
   output logic [CSR_W-1:0]   csr_prdata,
   output logic               csr_pready
);

   // Sequencer codes.
   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_DISPATCH = 3'd1;
   localparam logic [2:0] S_DIVIDE   = 3'd2;
   localparam logic [2:0] S_STEP     = 3'd3;
   localparam logic [2:0] S_EVAL     = 3'd4;
   localparam logic [2:0] S_FINISH   = 3'd5;

   localparam int CNT_W = $clog2(DIV_STEPS + 1);
   localparam logic [CNT_W-1:0] DIV_LOAD = CNT_W'(DIV_STEPS);

   // Sequencer and captured word.
   logic [2:0]          state_ff, state_in;
   logic [1:0]          op_ff;
   logic [VALUE_W-1:0]  tgt_ff, meas_ff;
   logic [TICK_W-1:0]   ticks_ff;
   logic                goff_ff;

   // Ramp and alarm state.
   logic [VALUE_W-1:0]  setpoint_ff, setpoint_in;
   logic [VALUE_W-1:0]  target_ff, target_in;
   logic [VALUE_W-1:0]  step_ff, step_in;
   logic [TICK_W-1:0]   remaining_ff, remaining_in;
   logic                ramp_on_ff, ramp_on_in;
   logic                c_timing_ff, c_timing_in;
   logic [TICK_W-1:0]   c_elapsed_ff, c_elapsed_in;
   logic                a_timing_ff, a_timing_in;
   logic [TICK_W-1:0]   a_elapsed_ff, a_elapsed_in;
   logic [1:0]          prev_ff, prev_in;
   logic                trip_ff, trip_in;

   // Serial divider.
   logic [TICK_W:0]     div_rem_ff, div_rem_in;
   logic [VALUE_W:0]    div_quo_ff, div_quo_in;
   logic                div_neg_ff, div_neg_in;
   logic [CNT_W-1:0]    div_cnt_ff, div_cnt_in;

   // Output register.
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]    rsp_data_ff, rsp_data_in;

   // Configuration registers.
   logic [THRESH_W-1:0] caution_thr_ff, alarm_thr_ff;
   logic [TICK_W-1:0]   delay_ff;
   logic                caution_en_ff, alarm_en_ff, shutdown_en_ff, point_off_ff;

   logic                req_take, cfg_write;
   logic [2:0]          cfg_index;

   // Datapath intermediates.
   logic [VALUE_W:0]    diff;
   logic [VALUE_W:0]    diff_mag;
   logic [TICK_W:0]     rem_shift;
   logic [TICK_W+1:0]   trial;
   logic [VALUE_W+1:0]  quo_signed;
   logic [VALUE_W:0]    ramp_sum;
   logic [TICK_W-1:0]   rem_dec;
   logic [VALUE_W:0]    dev;
   logic [VALUE_W:0]    dev_mag;
   logic                c_over, a_over;
   logic [TICK_W-1:0]   c_inc, a_inc;
   logic [1:0]          st;

   assign req_tready = (state_ff == S_IDLE);
   assign req_take   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Register port decode; pready is tied high.
   assign csr_pready = 1'b1;
   assign cfg_index  = csr_paddr[ADDR_W-1:2];
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      case (cfg_index)
         REG_CAUTION_THRESHOLD: csr_prdata = CSR_W'(caution_thr_ff);
         REG_ALARM_THRESHOLD:   csr_prdata = CSR_W'(alarm_thr_ff);
         REG_DELAY_TICKS:       csr_prdata = CSR_W'(delay_ff);
         REG_CAUTION_ENABLE:    csr_prdata = CSR_W'(caution_en_ff);
         REG_ALARM_ENABLE:      csr_prdata = CSR_W'(alarm_en_ff);
         REG_SHUTDOWN_ON_ALARM: csr_prdata = CSR_W'(shutdown_en_ff);
         REG_POINT_ALARMS_OFF:  csr_prdata = CSR_W'(point_off_ff);
         default:               csr_prdata = '0;
      endcase
   end

   // Shared arithmetic terms.
   always_comb begin
      // Ramp distance, target minus setpoint, and its magnitude.
      diff     = {tgt_ff[VALUE_W-1], tgt_ff} - {setpoint_ff[VALUE_W-1], setpoint_ff};
      diff_mag = diff[VALUE_W] ? (~diff + 1'b1) : diff;

      // One restoring division step.
      rem_shift = {div_rem_ff[TICK_W-1:0], div_quo_ff[VALUE_W]};
      trial     = {1'b0, rem_shift} - {2'b00, ticks_ff};

      // Signed quotient, truncated toward zero.
      quo_signed = div_neg_ff ? (~{1'b0, div_quo_ff} + 1'b1) : {1'b0, div_quo_ff};

      // Ramp advance.
      ramp_sum = {setpoint_ff[VALUE_W-1], setpoint_ff} + {step_ff[VALUE_W-1], step_ff};
      rem_dec  = (remaining_ff != '0) ? remaining_ff - 1'b1 : remaining_ff;

      // Deviation of the setpoint from the measured value.
      dev     = {setpoint_ff[VALUE_W-1], setpoint_ff} - {meas_ff[VALUE_W-1], meas_ff};
      dev_mag = dev[VALUE_W] ? (~dev + 1'b1) : dev;
      c_over  = caution_en_ff && (dev_mag > {2'b00, caution_thr_ff});
      a_over  = alarm_en_ff && (dev_mag > {2'b00, alarm_thr_ff});
      c_inc   = c_timing_ff ? tick_inc(c_elapsed_ff) : c_elapsed_ff;
      a_inc   = a_timing_ff ? tick_inc(a_elapsed_ff) : a_elapsed_ff;
   end

   // Sequencer and next state of all datapath registers.
   always_comb begin
      state_in     = state_ff;
      setpoint_in  = setpoint_ff;
      target_in    = target_ff;
      step_in      = step_ff;
      remaining_in = remaining_ff;
      ramp_on_in   = ramp_on_ff;
      c_timing_in  = c_timing_ff;
      c_elapsed_in = c_elapsed_ff;
      a_timing_in  = a_timing_ff;
      a_elapsed_in = a_elapsed_ff;
      prev_in      = prev_ff;
      trip_in      = trip_ff;
      div_rem_in   = div_rem_ff;
      div_quo_in   = div_quo_ff;
      div_neg_in   = div_neg_ff;
      div_cnt_in   = div_cnt_ff;
      st           = ST_NORMAL;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               state_in = S_DISPATCH;
            end
         end

         S_DISPATCH: begin
            trip_in  = 1'b0;
            state_in = S_FINISH;
            case (op_ff)
               OP_SET_TARGET: begin
                  if (ticks_ff != '0) begin
                     // Start a ramp; the step comes from the divider.
                     ramp_on_in   = 1'b1;
                     target_in    = tgt_ff;
                     remaining_in = ticks_ff;
                     div_rem_in   = '0;
                     div_quo_in   = diff_mag;
                     div_neg_in   = diff[VALUE_W];
                     div_cnt_in   = DIV_LOAD;
                     state_in     = S_DIVIDE;
                  end else begin
                     setpoint_in  = tgt_ff;
                     ramp_on_in   = 1'b0;
                     remaining_in = '0;
                  end
               end
               OP_TICK: begin
                  // Advance the ramp, then grade the deviation next cycle.
                  if (ramp_on_ff) begin
                     setpoint_in  = sat_one(ramp_sum);
                     remaining_in = rem_dec;
                     if (rem_dec == '0) begin
                        setpoint_in = target_ff;
                        ramp_on_in  = 1'b0;
                     end
                  end
                  state_in = S_EVAL;
               end
               OP_RESET_ALARM: begin
                  prev_in      = ST_NORMAL;
                  c_timing_in  = 1'b0;
                  c_elapsed_in = '0;
                  a_timing_in  = 1'b0;
                  a_elapsed_in = '0;
               end
               default: begin
               end
            endcase
         end

         S_DIVIDE: begin
            if (!trial[TICK_W+1]) begin
               div_rem_in = trial[TICK_W:0];
            end else begin
               div_rem_in = rem_shift;
            end
            div_quo_in = {div_quo_ff[VALUE_W-1:0], !trial[TICK_W+1]};
            div_cnt_in = div_cnt_ff - 1'b1;
            if (div_cnt_ff == CNT_W'(1)) begin
               state_in = S_STEP;
            end
         end

         S_STEP: begin
            step_in  = sat_two(quo_signed);
            state_in = S_FINISH;
         end

         S_EVAL: begin
            if (point_off_ff || goff_ff) begin
               c_timing_in  = 1'b0;
               c_elapsed_in = '0;
               a_timing_in  = 1'b0;
               a_elapsed_in = '0;
            end else begin
               // Caution: escalate from normal only after the delay has run.
               if (c_over) begin
                  c_elapsed_in = c_inc;
                  if (prev_ff == ST_NORMAL) begin
                     if (!c_timing_ff) begin
                        c_timing_in  = 1'b1;
                        c_elapsed_in = '0;
                     end else if (c_inc > delay_ff) begin
                        st = ST_CAUTION;
                     end
                  end else begin
                     st = ST_CAUTION;
                  end
               end else begin
                  c_timing_in  = 1'b0;
                  c_elapsed_in = '0;
               end
               // Alarm: held while in alarm, otherwise delayed escalation.
               if (a_over) begin
                  a_elapsed_in = a_inc;
                  if (prev_ff == ST_ALARM) begin
                     st = ST_ALARM;
                  end else if (!a_timing_ff) begin
                     a_timing_in  = 1'b1;
                     a_elapsed_in = '0;
                  end else if (a_inc > delay_ff) begin
                     st = ST_ALARM;
                  end
               end else begin
                  a_timing_in  = 1'b0;
                  a_elapsed_in = '0;
               end
            end
            prev_in  = st;
            trip_in  = (st == ST_ALARM) && shutdown_en_ff;
            state_in = S_FINISH;
         end

         S_FINISH: begin
            // Load the result once the output register is free.
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0000, trip_ff, prev_ff, ramp_on_ff, setpoint_ff};
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         setpoint_ff    <= '0;
         target_ff      <= '0;
         step_ff        <= '0;
         remaining_ff   <= '0;
         ramp_on_ff     <= 1'b0;
         c_timing_ff    <= 1'b0;
         c_elapsed_ff   <= '0;
         a_timing_ff    <= 1'b0;
         a_elapsed_ff   <= '0;
         prev_ff        <= ST_NORMAL;
         trip_ff        <= 1'b0;
         div_cnt_ff     <= '0;
         rsp_valid_ff   <= 1'b0;
         caution_thr_ff <= '0;
         alarm_thr_ff   <= '0;
         delay_ff       <= '0;
         caution_en_ff  <= 1'b0;
         alarm_en_ff    <= 1'b0;
         shutdown_en_ff <= 1'b0;
         point_off_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         setpoint_ff  <= setpoint_in;
         target_ff    <= target_in;
         step_ff      <= step_in;
         remaining_ff <= remaining_in;
         ramp_on_ff   <= ramp_on_in;
         c_timing_ff  <= c_timing_in;
         c_elapsed_ff <= c_elapsed_in;
         a_timing_ff  <= a_timing_in;
         a_elapsed_ff <= a_elapsed_in;
         prev_ff      <= prev_in;
         trip_ff      <= trip_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_write) begin
            case (cfg_index)
               REG_CAUTION_THRESHOLD: caution_thr_ff <= csr_pwdata[THRESH_W-1:0];
               REG_ALARM_THRESHOLD:   alarm_thr_ff   <= csr_pwdata[THRESH_W-1:0];
               REG_DELAY_TICKS:       delay_ff       <= csr_pwdata[TICK_W-1:0];
               REG_CAUTION_ENABLE:    caution_en_ff  <= csr_pwdata[0];
               REG_ALARM_ENABLE:      alarm_en_ff    <= csr_pwdata[0];
               REG_SHUTDOWN_ON_ALARM: shutdown_en_ff <= csr_pwdata[0];
               REG_POINT_ALARMS_OFF:  point_off_ff   <= csr_pwdata[0];
               default: begin
               end
            endcase
         end
      end
   end

   // Payload registers: captured word, divider data and result word.
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_tuser;
         tgt_ff   <= req_tdata[VALUE_W-1:0];
         ticks_ff <= req_tdata[VALUE_W+TICK_W-1:VALUE_W];
         meas_ff  <= req_tdata[2*VALUE_W+TICK_W-1:VALUE_W+TICK_W];
         goff_ff  <= req_tdata[2*VALUE_W+TICK_W];
      end
      div_rem_ff  <= div_rem_in;
      div_quo_ff  <= div_quo_in;
      div_neg_ff  <= div_neg_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Setpoint ramp and deviation alarm testbench
// Drives command words into the ramp and alarm block and predicts every status
// word from its own copy of the setpoint, ramp, delay timers and alarm state.
// A short table of directed words and register writes comes first, then
// random phases, each under a fresh register setting, with random gaps on
// both sides and one long output stall.
// ----------------------------------------------------------------------------
module tb_top;
   import sprda_pkg::*;

   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          RANDOM_WORDS = 1180;
   localparam int          CALM_WORDS   = 150;
   localparam int          HOLD_CYCLES  = 400;
   localparam int          HOLD_AT      = 300;
   localparam logic [1:0]  OP_UNUSED    = 2'd3;
   localparam logic [31:0] MASK_THR     = 32'h7FFF_FFFF;
   localparam logic [31:0] MASK_TICKS   = 32'h0000_FFFF;
   localparam logic [31:0] MASK_FLAG    = 32'h0000_0001;
   localparam longint      V_HI         = 64'sd2147483647;
   localparam longint      V_LO         = -64'sd2147483648;

   // One command word, fields in the order of the request tdata.
   typedef struct packed {
      logic [1:0]         op;
      logic signed [31:0] target;
      logic [15:0]        ticks;
      logic signed [31:0] meas;
      logic               goff;
   } cmd_type;

   // One status word, fields in the order of the response tdata.
   typedef struct packed {
      logic signed [31:0] setpoint;
      logic               ramp;
      logic [1:0]         state;
      logic               trip;
   } status_type;

   typedef enum logic [1:0] {ROW_CSR, ROW_PREDICTED, ROW_CHECKED} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      cmd_type      cmd;
      status_type   want;
      logic [2:0]   reg_idx;
      logic [31:0]  reg_val;
   } row_type;

   localparam cmd_type    NO_CMD    = '0;
   localparam status_type NO_STATUS = '0;

   // Directed table: register writes and command words, with the expected
   // status typed in only where it is obvious.
   localparam int NPLAN = 39;
   localparam row_type PLAN [NPLAN] = '{
      // Registers at reset: nothing enabled.
      '{ROW_CHECKED, '{OP_TICK, 32'h0, 16'd0, 32'h0, 1'b0}, '{32'h0, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      '{ROW_CHECKED, '{OP_TICK, 32'h0, 16'd0, 32'h8000_0000, 1'b1},
        '{32'h0, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      '{ROW_CHECKED, '{OP_SET_TARGET, 32'h7FFF_FFFF, 16'd0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      '{ROW_CHECKED, '{OP_SET_TARGET, 32'h8000_0000, 16'd0, 32'h0, 1'b0},
        '{32'h8000_0000, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      // Unused operation code with every field bit set is ignored.
      '{ROW_CHECKED, '{OP_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1},
        '{32'h8000_0000, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      // Full-range one-tick ramp: the step saturates, the tick lands on target.
      '{ROW_CHECKED, '{OP_SET_TARGET, 32'h7FFF_FFFF, 16'd1, 32'h0, 1'b0},
        '{32'h8000_0000, 1'b1, ST_NORMAL, 1'b0}, '0, '0},
      '{ROW_CHECKED, '{OP_TICK, 32'h0, 16'd0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      // Longest ramp over the full range, then cancelled by an immediate set.
      '{ROW_PREDICTED, '{OP_SET_TARGET, 32'h8000_0000, 16'hFFFF, 32'h0, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h7FFF_0000, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_CHECKED, '{OP_SET_TARGET, 32'h0, 16'd0, 32'h0, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_CHECKED, '{OP_RESET_ALARM, 32'h0, 16'd0, 32'h0, 1'b0}, NO_STATUS, '0, '0},
      // Small thresholds, one tick of delay, everything enabled.
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_CAUTION_THRESHOLD, 32'h0000_0100},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_ALARM_THRESHOLD, 32'h0000_1000},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_DELAY_TICKS, 32'h0000_0001},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_CAUTION_ENABLE, 32'hFFFF_FFFF},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_ALARM_ENABLE, 32'h0000_0001},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_SHUTDOWN_ON_ALARM, 32'h0000_0001},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_POINT_ALARMS_OFF, 32'h0000_0000},
      // Caution escalates after the delay, then alarm with a trip.
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h0000_0200, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h0000_0200, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h0000_0200, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'hFFFF_E000, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'hFFFF_E000, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'hFFFF_E000, 1'b0}, NO_STATUS, '0, '0},
      // System-wide disable drops the state at once.
      '{ROW_CHECKED, '{OP_TICK, 32'h0, 16'd0, 32'hFFFF_E000, 1'b1}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h8000_0000, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_CHECKED, '{OP_RESET_ALARM, 32'h0, 16'd0, 32'h0, 1'b0}, NO_STATUS, '0, '0},
      // Largest thresholds and delay, detection off for this point.
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_CAUTION_THRESHOLD, 32'hFFFF_FFFF},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_ALARM_THRESHOLD, 32'h7FFF_FFFF},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_DELAY_TICKS, 32'h0000_FFFF},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_POINT_ALARMS_OFF, 32'h0000_0001},
      '{ROW_CHECKED, '{OP_SET_TARGET, 32'h7FFF_FFFF, 16'd0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      '{ROW_CHECKED, '{OP_TICK, 32'h0, 16'd0, 32'h8000_0000, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, ST_NORMAL, 1'b0}, '0, '0},
      // Zero delay and the largest possible deviation.
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_POINT_ALARMS_OFF, 32'h0000_0000},
      '{ROW_CSR, NO_CMD, NO_STATUS, REG_DELAY_TICKS, 32'h0000_0000},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h8000_0000, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h8000_0000, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_PREDICTED, '{OP_TICK, 32'h0, 16'd0, 32'h7FFF_FFFF, 1'b0}, NO_STATUS, '0, '0},
      '{ROW_CHECKED, '{OP_RESET_ALARM, 32'h0, 16'd0, 32'h0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, ST_NORMAL, 1'b0}, '0, '0}
   };

   // Block ports; every input starts at a known value.
   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_tvalid  = 1'b0;
   logic              req_tready;
   logic [REQ_W-1:0]  req_tdata   = '0;
   logic [1:0]        req_tuser   = OP_SET_TARGET;
   logic              rsp_tvalid;
   logic              rsp_tready  = 1'b0;
   logic [RSP_W-1:0]  rsp_tdata;
   logic              csr_psel    = 1'b0;
   logic              csr_penable = 1'b0;
   logic              csr_pwrite  = 1'b0;
   logic [ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_W-1:0]  csr_pwdata  = '0;
   logic [CSR_W-1:0]  csr_prdata;
   logic              csr_pready;

   // Predicted register settings.
   logic [30:0] caution_thr = '0;
   logic [30:0] alarm_thr   = '0;
   logic [15:0] delay_ticks = '0;
   logic        caution_en  = 1'b0;
   logic        alarm_en    = 1'b0;
   logic        shutdown_en = 1'b0;
   logic        point_off   = 1'b0;

   // Predicted ramp and alarm state.
   logic signed [31:0] setpoint   = '0;
   logic signed [31:0] ramp_goal  = '0;
   logic signed [31:0] ramp_inc   = '0;
   logic [15:0]        ramp_left  = '0;
   logic               ramp_on    = 1'b0;
   logic               c_timing   = 1'b0;
   logic [15:0]        c_count    = '0;
   logic               a_timing   = 1'b0;
   logic [15:0]        a_count    = '0;
   logic [1:0]         held_state = ST_NORMAL;

   status_type  expected_status [$];
   int          mismatches = 0;
   int unsigned cycles     = 0;
   bit          src_idle   = 1'b0;
   bit          sink_idle  = 1'b0;
   bit          hold_req   = 1'b0;

   setpoint_ramp_deviation_alarm DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #4 clock = ~clock;

   // Run limit.
   always @(posedge clock) begin
      cycles++;
      if (cycles == CYCLE_LIMIT) begin
         $display("** setpoint_ramp_deviation_alarm: FAILED **");
         $finish;
      end
   end

   // Clamp a wide signed value to the Q16.16 range.
   function automatic logic signed [31:0] clamp(longint v);
      if (v > V_HI) return VALUE_MAX;
      if (v < V_LO) return VALUE_MIN;
      return v[31:0];
   endfunction

   // Delay counter step that holds at its top value.
   function automatic logic [15:0] bump(logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic void idle_timers();
      c_timing = 1'b0;
      c_count  = '0;
      a_timing = 1'b0;
      a_count  = '0;
   endfunction

   // Advance the predicted state by one accepted command word and return the
   // status word it must produce.
   function automatic status_type ramp_alarm_predict(cmd_type w);
      status_type r;
      logic [1:0] st;
      longint     diff;
      longint     mag;
      st     = ST_NORMAL;
      r.trip = 1'b0;
      case (w.op)
         OP_SET_TARGET: begin
            if (w.ticks != 16'd0) begin
               ramp_on   = 1'b1;
               ramp_goal = w.target;
               ramp_left = w.ticks;
               ramp_inc  = clamp((longint'($signed(w.target)) - longint'(setpoint))
                                 / longint'(w.ticks));
            end else begin
               setpoint  = w.target;
               ramp_on   = 1'b0;
               ramp_left = '0;
            end
         end
         OP_TICK: begin
            // The ramp moves before the deviation is graded.
            if (ramp_on) begin
               setpoint = clamp(longint'(setpoint) + longint'(ramp_inc));
               if (ramp_left != 16'd0) ramp_left--;
               if (ramp_left == 16'd0) begin
                  setpoint = ramp_goal;
                  ramp_on  = 1'b0;
               end
            end
            if (point_off || w.goff) begin
               idle_timers();
            end else begin
               diff = longint'(setpoint) - longint'($signed(w.meas));
               mag  = (diff < 0) ? -diff : diff;
               if (caution_en && mag > longint'(caution_thr)) begin
                  if (c_timing) c_count = bump(c_count);
                  if (held_state == ST_NORMAL) begin
                     if (!c_timing) begin
                        c_timing = 1'b1;
                        c_count  = '0;
                     end else if (c_count > delay_ticks) begin
                        st = ST_CAUTION;
                     end
                  end else begin
                     st = ST_CAUTION;
                  end
               end else begin
                  c_timing = 1'b0;
                  c_count  = '0;
               end
               if (alarm_en && mag > longint'(alarm_thr)) begin
                  if (a_timing) a_count = bump(a_count);
                  if (held_state == ST_ALARM) begin
                     st = ST_ALARM;
                  end else if (!a_timing) begin
                     a_timing = 1'b1;
                     a_count  = '0;
                  end else if (a_count > delay_ticks) begin
                     st = ST_ALARM;
                  end
               end else begin
                  a_timing = 1'b0;
                  a_count  = '0;
               end
            end
            held_state = st;
            r.trip     = (st == ST_ALARM) && shutdown_en;
         end
         OP_RESET_ALARM: begin
            held_state = ST_NORMAL;
            idle_timers();
         end
         default: begin
         end
      endcase
      r.setpoint = setpoint;
      r.ramp     = ramp_on;
      r.state    = held_state;
      return r;
   endfunction

   // Random command word; measured values mostly sit near the thresholds
   // around the current setpoint so that the timers and states get exercised.
   function automatic cmd_type random_cmd();
      cmd_type     w;
      int unsigned pick;
      longint      off;
      w.target = $urandom;
      w.ticks  = 16'($urandom);
      w.meas   = $urandom;
      w.goff   = ($urandom_range(0, 9) == 0);
      pick     = $urandom_range(0, 99);
      if (pick < 60) begin
         w.op = OP_TICK;
         case ($urandom_range(0, 9))
            0, 1:    off = -1;
            2, 3, 4: off = longint'(caution_thr) + int'($urandom_range(0, 4)) - 2;
            5, 6, 7: off = longint'(alarm_thr) + int'($urandom_range(0, 4)) - 2;
            default: off = longint'($urandom_range(0, 3));
         endcase
         if (off >= 0) begin
            if ($urandom_range(0, 1)) off = -off;
            w.meas = clamp(longint'(setpoint) + off);
         end
      end else if (pick < 82) begin
         w.op = OP_SET_TARGET;
         case ($urandom_range(0, 7))
            0, 1:    w.target = $urandom;
            2:       w.target = $urandom_range(0, 1) ? VALUE_MAX : VALUE_MIN;
            default: w.target = clamp(longint'(setpoint) + longint'($urandom_range(0, 1 << 20))
                                      - (1 << 19));
         endcase
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: w.ticks = '0;
            15, 16, 17:    w.ticks = 16'($urandom_range(9, 300));
            18, 19:        w.ticks = 16'($urandom);
            default:       w.ticks = 16'($urandom_range(1, 8));
         endcase
      end else if (pick < 92) begin
         w.op = OP_RESET_ALARM;
      end else begin
         w.op = OP_UNUSED;
      end
      return w;
   endfunction

   // Offer one word, wait for it to be taken, and queue its status.
   // Entered and left at a falling edge.
   task automatic send_cmd(cmd_type w, bit typed, status_type want);
      status_type p;
      req_tuser  <= w.op;
      req_tdata  <= {7'b0, w.goff, w.meas, w.ticks, w.target};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      p = ramp_alarm_predict(w);
      expected_status.push_back(typed ? want : p);
      @(negedge clock);
      if (src_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
   endtask

   // Stop offering and wait until every status word has come back.
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (expected_status.size() != 0);
   endtask

   // Register write followed by a read-back of the stored bits.
   task automatic csr_write(logic [2:0] idx, logic [31:0] val);
      logic [31:0] got;
      logic [31:0] mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= val;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      got = csr_prdata;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
      case (idx)
         REG_CAUTION_THRESHOLD: begin
            caution_thr = val[30:0];
            mask        = MASK_THR;
         end
         REG_ALARM_THRESHOLD: begin
            alarm_thr = val[30:0];
            mask      = MASK_THR;
         end
         REG_DELAY_TICKS: begin
            delay_ticks = val[15:0];
            mask        = MASK_TICKS;
         end
         REG_CAUTION_ENABLE: begin
            caution_en = val[0];
            mask       = MASK_FLAG;
         end
         REG_ALARM_ENABLE: begin
            alarm_en = val[0];
            mask     = MASK_FLAG;
         end
         REG_SHUTDOWN_ON_ALARM: begin
            shutdown_en = val[0];
            mask        = MASK_FLAG;
         end
         default: begin
            point_off = val[0];
            mask      = MASK_FLAG;
         end
      endcase
      if (got !== (val & mask)) begin
         $error("register %0d read-back: expected %h, got %h", idx, val & mask, got);
         mismatches++;
      end
   endtask

   // Sometimes set the bits above a register's width as well.
   function automatic logic [31:0] with_junk(logic [31:0] v, logic [31:0] mask);
      return ($urandom_range(0, 3) == 0) ? (v | ($urandom & ~mask)) : v;
   endfunction

   // Fresh register setting for one random phase, extremes included.
   task automatic random_config();
      logic [30:0] c;
      logic [30:0] a;
      logic [30:0] t;
      logic [15:0] d;
      case ($urandom_range(0, 9))
         0: begin
            c = '0;
            a = '0;
         end
         1: begin
            c = '1;
            a = '1;
         end
         default: begin
            c = 31'($urandom) >> $urandom_range(0, 30);
            a = 31'($urandom) >> $urandom_range(0, 30);
            if (a < c && $urandom_range(0, 3) != 0) begin
               t = a;
               a = c;
               c = t;
            end
         end
      endcase
      case ($urandom_range(0, 9))
         6, 7:    d = 16'($urandom_range(4, 20));
         8:       d = 16'hFFFF;
         9:       d = 16'($urandom);
         default: d = 16'($urandom_range(0, 3));
      endcase
      csr_write(REG_CAUTION_THRESHOLD, with_junk({1'b0, c}, MASK_THR));
      csr_write(REG_ALARM_THRESHOLD, with_junk({1'b0, a}, MASK_THR));
      csr_write(REG_DELAY_TICKS, with_junk({16'b0, d}, MASK_TICKS));
      csr_write(REG_CAUTION_ENABLE, with_junk({31'b0, $urandom_range(0, 3) != 0}, MASK_FLAG));
      csr_write(REG_ALARM_ENABLE, with_junk({31'b0, $urandom_range(0, 3) != 0}, MASK_FLAG));
      csr_write(REG_SHUTDOWN_ON_ALARM, with_junk({31'b0, $urandom_range(0, 1) != 0}, MASK_FLAG));
      csr_write(REG_POINT_ALARMS_OFF, with_junk({31'b0, $urandom_range(0, 7) == 0}, MASK_FLAG));
   endtask

   // Status word receiver: random stalls, and one long hold on request.
   initial begin : status_sink
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_req = 1'b0;
            rsp_tready <= 1'b1;
         end else if (sink_idle && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 7)) @(negedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // Compare each status word with the oldest prediction.
   always @(posedge clock) begin : status_check
      status_type want;
      status_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[31:0], rsp_tdata[32], rsp_tdata[34:33], rsp_tdata[35]};
         if (expected_status.size() == 0) begin
            $error("status word %h arrived with nothing expected", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_status.pop_front();
            if (got.setpoint !== want.setpoint) begin
               $error("current_setpoint: expected %h, got %h", want.setpoint, got.setpoint);
               mismatches++;
            end
            if (got.ramp !== want.ramp) begin
               $error("ramp_active: expected %0d, got %0d", want.ramp, got.ramp);
               mismatches++;
            end
            if (got.state !== want.state) begin
               $error("alarm_state: expected %0d, got %0d", want.state, got.state);
               mismatches++;
            end
            if (got.trip !== want.trip) begin
               $error("shutdown_trip: expected %0d, got %0d", want.trip, got.trip);
               mismatches++;
            end
         end
      end
   end

   // Main sequence: reset, directed table, random phases, drain.
   initial begin : stimulus
      int sent;
      int len;
      int i;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (PLAN[n]) begin
         case (PLAN[n].kind)
            ROW_CSR: begin
               settle();
               csr_write(PLAN[n].reg_idx, PLAN[n].reg_val);
            end
            ROW_CHECKED:   send_cmd(PLAN[n].cmd, 1'b1, PLAN[n].want);
            default:       send_cmd(PLAN[n].cmd, 1'b0, NO_STATUS);
         endcase
      end

      sent = 0;
      while (sent < RANDOM_WORDS) begin
         settle();
         random_config();
         src_idle  = ($urandom_range(0, 3) != 0);
         sink_idle = ($urandom_range(0, 3) != 0);
         len = $urandom_range(40, 120);
         for (i = 0; i < len && sent < RANDOM_WORDS; i++) begin
            // The closing stretch runs without gaps on either side.
            if (sent >= RANDOM_WORDS - CALM_WORDS) begin
               src_idle  = 1'b0;
               sink_idle = 1'b0;
            end
            if (sent == HOLD_AT) hold_req = 1'b1;
            send_cmd(random_cmd(), 1'b0, NO_STATUS);
            sent++;
         end
      end

      settle();
      repeat (8) @(negedge clock);
      if (mismatches == 0 && expected_status.size() == 0) begin
         $display("** setpoint_ramp_deviation_alarm: PASSED **");
      end else begin
         $display("** setpoint_ramp_deviation_alarm: FAILED **");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/sprda_pkg.sv
hdl/setpoint_ramp_deviation_alarm.sv
sim/tb_top.sv
